>>> src/iwt_pkg.sv
// Shared types, token codes and digit helpers for the integer-to-word-token block.
package iwt_pkg;

  localparam int unsigned ValW      = 31;
  localparam int unsigned PowW      = ValW + 4;
  localparam int unsigned NumDigits = 10;
  localparam int unsigned TokW      = 5;
  localparam int unsigned NumGroups = 4;
  localparam int unsigned GrpSlots  = 5;
  localparam int unsigned SlotW     = 3;
  localparam int unsigned GrpW      = 2;
  localparam int unsigned FifoDepth = 2;

  // Word token codes
  localparam logic [TokW-1:0] TokZero     = 5'd0;
  localparam logic [TokW-1:0] TokTenBase  = 5'd10;
  localparam logic [TokW-1:0] TokTensBase = 5'd18;
  localparam logic [TokW-1:0] TokHundred  = 5'd28;
  localparam logic [TokW-1:0] TokThousand = 5'd29;
  localparam logic [TokW-1:0] TokMillion  = 5'd30;
  localparam logic [TokW-1:0] TokBillion  = 5'd31;

  typedef logic [3:0] bcd_t;
  // Index 0 is the most significant (billions) digit
  typedef bcd_t [NumDigits-1:0] digits_t;

  // Place value of each digit position, most significant first
  localparam logic [PowW-1:0] POW10 [NumDigits] = '{
    35'd1000000000, 35'd100000000, 35'd10000000, 35'd1000000, 35'd100000,
    35'd10000, 35'd1000, 35'd100, 35'd10, 35'd1
  };

  typedef struct packed {
    bcd_t            digit;
    logic [ValW-1:0] rem;
  } step_t;

  // Word tokens of one three-digit group and how many there are
  typedef struct packed {
    logic [GrpSlots-1:0][TokW-1:0] tok;
    logic [SlotW-1:0]              cnt;
  } grp_tok_t;

  // Pull one decimal digit off a remainder at a given place value
  function automatic step_t dec_step(input logic [ValW-1:0] r, input logic [PowW-1:0] pw);
    step_t           s;
    logic [PowW-1:0] m;
    logic [PowW-1:0] sel;
    s     = '0;
    sel   = '0;
    for (int k = 1; k < 10; k++) begin
      m = pw * PowW'(k);
      if ({4'b0000, r} >= m) begin
        s.digit = 4'(k);
        sel     = m;
      end
    end
    s.rem = r - sel[ValW-1:0];
    return s;
  endfunction

  // Build the token list of one group: hundreds, tens or teen, units, scale
  function automatic grp_tok_t group_tokens(input bcd_t h, input bcd_t t, input bcd_t u,
                                            input logic has_scale,
                                            input logic [TokW-1:0] scale);
    grp_tok_t         g;
    logic [SlotW-1:0] n;
    g = '0;
    n = '0;
    if (h != 4'd0) begin
      g.tok[n] = {1'b0, h};
      n        = n + 3'd1;
      g.tok[n] = TokHundred;
      n        = n + 3'd1;
    end
    if (t >= 4'd2) begin
      g.tok[n] = TokTensBase + {1'b0, t};
      n        = n + 3'd1;
      if (u != 4'd0) begin
        g.tok[n] = {1'b0, u};
        n        = n + 3'd1;
      end
    end else if (t == 4'd1) begin
      g.tok[n] = TokTenBase + {1'b0, u};
      n        = n + 3'd1;
    end else if (u != 4'd0) begin
      g.tok[n] = {1'b0, u};
      n        = n + 3'd1;
    end
    if ((n != 3'd0) && has_scale) begin
      g.tok[n] = scale;
      n        = n + 3'd1;
    end
    g.cnt = n;
    return g;
  endfunction

endpackage

>>> src/iwt_front.sv
// Front end: pipelined binary-to-decimal split, one digit per stage.
module iwt_front import iwt_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [ValW-1:0] value_i,
  output logic            push_valid_o,
  input  logic            push_ready_i,
  output digits_t         push_digits_o
);

  logic [NumDigits-1:0] vld_q;
  logic [ValW-1:0]      rem_q [NumDigits-1];
  digits_t              dig_q [NumDigits];
  logic                 adv;

  // Advance the whole pipe unless the last stage is held by a full queue
  assign adv          = !vld_q[NumDigits-1] || push_ready_i;
  assign in_ready_o   = adv;
  assign push_valid_o = vld_q[NumDigits-1];
  assign push_digits_o = dig_q[NumDigits-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NumDigits-2:0], in_valid_i};
    end
  end

  for (genvar k = 0; k < NumDigits; k++) begin : g_stage
    logic [ValW-1:0] rin;
    digits_t         din;
    digits_t         dnext;
    step_t           st;

    if (k == 0) begin : g_first
      assign rin = value_i;
      assign din = '0;
    end else begin : g_rest
      assign rin = rem_q[k-1];
      assign din = dig_q[k-1];
    end

    // Extract the digit at this place value
    always_comb begin
      st       = dec_step(rin, POW10[k]);
      dnext    = din;
      dnext[k] = st.digit;
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dig_q[k] <= dnext;
      end
    end

    if (k < NumDigits - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (adv) begin
          rem_q[k] <= st.rem;
        end
      end
    end
  end

endmodule

>>> src/iwt_fifo.sv
// Small request queue between the digit front end and the token back end.
module iwt_fifo import iwt_pkg::*; #(
  parameter int unsigned Depth = FifoDepth
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_valid_i,
  output logic    push_ready_o,
  input  digits_t push_data_i,
  output logic    pop_valid_o,
  input  logic    pop_ready_i,
  output digits_t pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  digits_t         mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  assign push_ready_o = cnt_q != CntW'(Depth);
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  // Store an incoming request
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

>>> src/iwt_back.sv
// Back end: walks the groups of one request and emits one word token a cycle while the receiver is ready.
module iwt_back import iwt_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            pop_valid_i,
  output logic            pop_ready_o,
  input  digits_t         pop_digits_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [TokW-1:0] word_token_o,
  output logic            last_word_o
);

  digits_t          dig_q;
  logic             busy_q, busy_d;
  logic [GrpW-1:0]  gi_q, gi_d;
  logic [SlotW-1:0] si_q, si_d;
  logic             oval_q;
  logic [TokW-1:0]  otok_q;
  logic             olast_q;

  grp_tok_t             grp [NumGroups];
  logic [NumGroups-1:0] nz;
  logic [GrpW-1:0]      cur;
  logic                 found, more;
  logic                 grp_done, last, emit, pop;
  logic [TokW-1:0]      tok;

  // Token lists of the billion, million, thousand and unit groups
  always_comb begin
    grp[0] = group_tokens(4'd0, 4'd0, dig_q[0], 1'b1, TokBillion);
    grp[1] = group_tokens(dig_q[1], dig_q[2], dig_q[3], 1'b1, TokMillion);
    grp[2] = group_tokens(dig_q[4], dig_q[5], dig_q[6], 1'b1, TokThousand);
    grp[3] = group_tokens(dig_q[7], dig_q[8], dig_q[9], 1'b0, TokZero);
    for (int g = 0; g < NumGroups; g++) begin
      nz[g] = grp[g].cnt != '0;
    end
  end

  // Find the current nonempty group and whether any follows it
  always_comb begin
    cur   = '0;
    found = 1'b0;
    more  = 1'b0;
    for (int g = NumGroups - 1; g >= 0; g--) begin
      if (nz[g] && (GrpW'(g) >= gi_q)) begin
        cur   = GrpW'(g);
        found = 1'b1;
      end
    end
    for (int g = 0; g < NumGroups; g++) begin
      if (nz[g] && (GrpW'(g) > cur)) begin
        more = 1'b1;
      end
    end
  end

  assign tok      = found ? grp[cur].tok[si_q] : TokZero;
  assign grp_done = !found || ((si_q + SlotW'(1)) == grp[cur].cnt);
  assign last     = grp_done && !more;
  assign emit     = busy_q && (!oval_q || out_ready_i);
  assign pop_ready_o = !busy_q || (emit && last);
  assign pop      = pop_valid_i && pop_ready_o;

  // Step through slots and groups; load the next request on the last token
  always_comb begin
    busy_d = busy_q;
    gi_d   = gi_q;
    si_d   = si_q;
    if (pop) begin
      busy_d = 1'b1;
      gi_d   = '0;
      si_d   = '0;
    end else if (emit && last) begin
      busy_d = 1'b0;
    end else if (emit) begin
      if (grp_done) begin
        gi_d = cur + GrpW'(1);
        si_d = '0;
      end else begin
        si_d = si_q + SlotW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      gi_q   <= '0;
      si_q   <= '0;
      oval_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      gi_q   <= gi_d;
      si_q   <= si_d;
      if (emit) begin
        oval_q <= 1'b1;
      end else if (out_ready_i) begin
        oval_q <= 1'b0;
      end
    end
  end

  // Hold the request digits and the output token
  always_ff @(posedge clk_i) begin
    if (pop) begin
      dig_q <= pop_digits_i;
    end
    if (emit) begin
      otok_q  <= tok;
      olast_q <= last;
    end
  end

  assign out_valid_o  = oval_q;
  assign word_token_o = otok_q;
  assign last_word_o  = olast_q;

endmodule

>>> src/integer_to_word_tokens_top.sv
// Top level of the integer-to-word-token converter.
//
// Input channel (in_valid_i/in_ready_o/value_i) takes one 31-bit value per
// request. Output channel (out_valid_o/out_ready_i) returns the English
// reading as word tokens, one per cycle while the receiver is ready, with
// last_word_o set on the final token of each value. Zero yields the
// single token Zero. A ten-stage front pipe splits the value into decimal
// digits, one digit per stage, and hands the digits through a short
// queue to the back end, which walks the billion, million, thousand and
// unit groups.
// Throughput: the back end emits one token per cycle while the receiver
// is ready, and a value has 1 to 16 tokens; the front keeps accepting
// values while earlier ones are emitted until the queue fills.
// Reset clears all valid flags and sequencing state; nothing is in flight.
// When the receiver stalls, the output register holds its token, the back
// end pauses, the queue fills and the front pipe and in_ready_o stall.
module integer_to_word_tokens_top import iwt_pkg::*; #(
  parameter int unsigned QueueDepth = FifoDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [ValW-1:0] value_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [TokW-1:0] word_token_o,
  output logic            last_word_o
);

  logic    push_valid, push_ready, pop_valid, pop_ready;
  digits_t push_digits, pop_digits;

  iwt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .value_i      (value_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_digits_o(push_digits)
  );

  iwt_fifo #(
    .Depth(QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_data_i (push_digits),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_data_o  (pop_digits)
  );

  iwt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_digits_i(pop_digits),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .word_token_o(word_token_o),
    .last_word_o (last_word_o)
  );

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for the integer-to-word-token converter.
module tb_top;
  import iwt_pkg::*;

  // One expected word of a spoken value
  typedef struct {
    logic [TokW-1:0] tok;
    logic            is_last;
  } word_t;

  logic            clk_i;
  logic            rst_ni;
  logic            in_valid_i;
  logic            in_ready_o;
  logic [ValW-1:0] value_i;
  logic            out_valid_o;
  logic            out_ready_i;
  logic [TokW-1:0] word_token_o;
  logic            last_word_o;

  word_t       spoken_words[$];
  int unsigned send_gap_pct;
  int unsigned recv_stall_pct;
  int unsigned mismatches;

  integer_to_word_tokens_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .word_token_o(word_token_o),
    .last_word_o (last_word_o)
  );

  // Toggle the clock every half period
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Append one word to the expected reading
  function automatic void say_word(input logic [TokW-1:0] tok);
    word_t w;
    w.tok     = tok;
    w.is_last = 1'b0;
    spoken_words.insert(spoken_words.size(), w);
  endfunction

  // Speak one three-digit group: hundreds, then tens or teen, then units
  function automatic void say_group(input int unsigned g);
    int unsigned h;
    int unsigned r;
    h = g / 100;
    r = g % 100;
    if (h > 0) begin
      say_word(TokW'(h));
      say_word(TokHundred);
    end
    if (r >= 20) begin
      say_word(TokTensBase + TokW'(r / 10));
      if (r % 10 != 0) say_word(TokW'(r % 10));
    end else if (r >= 10) begin
      say_word(TokTenBase + TokW'(r - 10));
    end else if (r > 0) begin
      say_word(TokW'(r));
    end
  endfunction

  // Work out the full word sequence of one accepted value
  function automatic void read_out_words(input logic [ValW-1:0] v);
    int unsigned n;
    n = int'(v);
    if (n == 0) begin
      say_word(TokZero);
    end else begin
      if (n / 1000000000 > 0) begin
        say_group(n / 1000000000);
        say_word(TokBillion);
      end
      n = n % 1000000000;
      if (n / 1000000 > 0) begin
        say_group(n / 1000000);
        say_word(TokMillion);
      end
      n = n % 1000000;
      if (n / 1000 > 0) begin
        say_group(n / 1000);
        say_word(TokThousand);
      end
      say_group(n % 1000);
    end
    spoken_words[$].is_last = 1'b1;
  endfunction

  // Send one request, idling at random first, and predict its words
  task automatic send_value(input logic [ValW-1:0] v);
    @(negedge clk_i);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      value_i    <= ValW'($urandom());
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    read_out_words(v);
  endtask

  // Drop valid once the last request is taken
  task automatic stop_sending();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // Hold until every expected word has come out
  task automatic wait_for_drain();
    while (spoken_words.size() != 0) @(posedge clk_i);
  endtask

  // Stall the receiver at random
  always @(negedge clk_i) begin
    if (rst_ni) out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each accepted word with the oldest expected one
  always @(posedge clk_i) begin : check_words
    word_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      if (spoken_words.size() == 0) begin
        $display("%0t: unexpected word: expected none, got token %0d last %0b",
                 $time, word_token_o, last_word_o);
        mismatches++;
      end else begin
        want = spoken_words.pop_front();
        if (word_token_o !== want.tok) begin
          $display("%0t: word token mismatch: expected %0d, got %0d",
                   $time, want.tok, word_token_o);
          mismatches++;
        end
        if (last_word_o !== want.is_last) begin
          $display("%0t: last word mismatch: expected %0b, got %0b",
                   $time, want.is_last, last_word_o);
          mismatches++;
        end
      end
    end
  end

  // Pick one three-digit group, leaning on zero and the teens
  function automatic int unsigned pick_group();
    int unsigned k;
    k = $urandom_range(7);
    if (k < 2) return 0;
    if (k < 4) return $urandom_range(9) * 100 + 10 + $urandom_range(9);
    if (k < 5) return $urandom_range(9) * 100 + $urandom_range(9) * 10;
    return $urandom_range(999);
  endfunction

  // Build a random value across all magnitudes
  function automatic logic [ValW-1:0] pick_value();
    int unsigned   kind;
    longint unsigned v;
    kind = $urandom_range(9);
    if (kind < 4) begin
      v = longint'($urandom_range(2)) * 1000000000 + longint'(pick_group()) * 1000000
          + longint'(pick_group()) * 1000 + longint'(pick_group());
      if (v > 64'd2147483647) v = v - 64'd1000000000;
      return ValW'(v);
    end
    if (kind < 6) return ValW'($urandom_range(999));
    if (kind < 7) return ValW'($urandom_range(999999));
    return ValW'($urandom());
  endfunction

  // Boundaries of every group, teens, tens, zero and the longest readings
  task automatic test_edge_values();
    logic [ValW-1:0] vals[$];
    vals = '{31'd0, 31'd1, 31'd9, 31'd10, 31'd11, 31'd19, 31'd20, 31'd21, 31'd99,
             31'd100, 31'd101, 31'd110, 31'd119, 31'd999, 31'd1000, 31'd1001,
             31'd1000000, 31'd1000000000, 31'd2000000000, 31'd1777777777,
             31'd1010101010, 31'd1234567890, 31'd2147483647, 31'd1999999999};
    foreach (vals[i]) send_value(vals[i]);
  endtask

  // Random values under the current idling
  task automatic test_random_values(input int unsigned count);
    repeat (count) send_value(pick_value());
  endtask

  // Let the block drain between bursts of requests
  task automatic test_drain_pause();
    repeat (3) begin
      repeat (5) send_value(pick_value());
      stop_sending();
      wait_for_drain();
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    value_i        = '0;
    out_ready_i    = 1'b0;
    mismatches     = 0;
    send_gap_pct   = 35;
    recv_stall_pct = 81;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_edge_values();
    test_drain_pause();
    test_random_values(130);

    send_gap_pct   = 81;
    recv_stall_pct = 35;
    test_random_values(130);

    send_gap_pct   = 0;
    recv_stall_pct = 0;
    test_random_values(130);

    stop_sending();
    wait_for_drain();
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // End a hung run
  initial begin
    #4000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
